[rtl/wshp_pkg.sv]
// Shared types, codes and word tables for the WebSocket handshake header parser.
// No dependencies.
`timescale 1ns / 1ps

package wshp_pkg;

   // pending line-end expectations
   localparam logic [2:0] PE_NONE        = 3'd0;
   localparam logic [2:0] PE_SKIP_BLANKS = 3'd1;
   localparam logic [2:0] PE_LF          = 3'd2;
   localparam logic [2:0] PE_LF_NOCONT   = 3'd3;
   localparam logic [2:0] PE_LF_END      = 3'd4;
   localparam logic [2:0] PE_LINE_CONT   = 3'd5;
   localparam logic [2:0] PE_LINE_NOCONT = 3'd6;

   // what ends the current token
   localparam logic [2:0] TE_SPACE      = 3'd0;
   localparam logic [2:0] TE_BLANKS     = 3'd1;
   localparam logic [2:0] TE_COLON      = 3'd2;
   localparam logic [2:0] TE_EOL        = 3'd3;
   localparam logic [2:0] TE_EOL_NOCONT = 3'd4;

   localparam logic [2:0] PH_METHOD  = 3'd0;
   localparam logic [2:0] PH_PATH    = 3'd1;
   localparam logic [2:0] PH_VERSION = 3'd2;
   localparam logic [2:0] PH_FIELD   = 3'd3;
   localparam logic [2:0] PH_VALUE   = 3'd4;

   localparam logic [2:0] HN_OTHER      = 3'd0;
   localparam logic [2:0] HN_UPGRADE    = 3'd1;
   localparam logic [2:0] HN_CONNECTION = 3'd2;
   localparam logic [2:0] HN_VERSION    = 3'd3;
   localparam logic [2:0] HN_KEY        = 3'd4;

   // tokenizer verdicts
   localparam logic [2:0] TK_CHAR        = 3'd0;
   localparam logic [2:0] TK_SKIP        = 3'd1;
   localparam logic [2:0] TK_ABORT       = 3'd2;
   localparam logic [2:0] TK_END         = 3'd3;
   localparam logic [2:0] TK_END_AGAIN   = 3'd4;
   localparam logic [2:0] TK_END_HEADERS = 3'd5;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_MALFORMED = 3'd1;
   localparam logic [2:0] ERR_TOO_LONG  = 3'd2;
   localparam logic [2:0] ERR_BAD_VALUE = 3'd3;
   localparam logic [2:0] ERR_REPEATED  = 3'd4;
   localparam logic [2:0] ERR_METHOD    = 3'd5;
   localparam logic [2:0] ERR_VERSION   = 3'd6;
   localparam logic [2:0] ERR_PATH      = 3'd7;

   localparam logic [1:0] ST_MORE   = 2'd0;
   localparam logic [1:0] ST_ACCEPT = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_VT  = 8'h0B;
   localparam logic [7:0] CH_FF  = 8'h0C;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   // words matched against the token buffer
   localparam int NUM_WORDS = 8;
   localparam logic [2:0] W_GET       = 3'd0;
   localparam logic [2:0] W_HTTP11    = 3'd1;
   localparam logic [2:0] W_UPGRADE   = 3'd2;
   localparam logic [2:0] W_CONNECT   = 3'd3;
   localparam logic [2:0] W_SECVER    = 3'd4;
   localparam logic [2:0] W_SECKEY    = 3'd5;
   localparam logic [2:0] W_WEBSOCKET = 3'd6;
   localparam logic [2:0] W_13        = 3'd7;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] ch;
      logic [2:0] pe_next;
   } tok_result_type;

   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SP || c == CH_TAB;
   endfunction

   function automatic logic [4:0] word_len(input logic [2:0] id);
      logic [4:0] l;
      case (id)
         W_GET:       l = 5'd3;
         W_HTTP11:    l = 5'd8;
         W_UPGRADE:   l = 5'd7;
         W_CONNECT:   l = 5'd10;
         W_SECVER:    l = 5'd21;
         W_SECKEY:    l = 5'd17;
         W_WEBSOCKET: l = 5'd9;
         default:     l = 5'd2;
      endcase
      return l;
   endfunction

   // case-insensitive words are stored in lower case
   function automatic logic word_folds(input logic [2:0] id);
      return id != W_GET && id != W_HTTP11 && id != W_13;
   endfunction

   function automatic logic [7:0] word_byte(input logic [2:0] id, input logic [4:0] k);
      logic [167:0] s;
      int           l;
      case (id)
         W_GET:       s = 168'("GET");
         W_HTTP11:    s = 168'("HTTP/1.1");
         W_UPGRADE:   s = 168'("upgrade");
         W_CONNECT:   s = 168'("connection");
         W_SECVER:    s = 168'("sec-websocket-version");
         W_SECKEY:    s = 168'("sec-websocket-key");
         W_WEBSOCKET: s = 168'("websocket");
         default:     s = 168'("13");
      endcase
      l = int'(word_len(id));
      if (int'(k) >= l) return 8'h00;
      return s[8 * (l - 1 - int'(k)) +: 8];
   endfunction

endpackage

[rtl/wshp_chan_if.sv]
// Valid/ready channel interfaces for request bytes and parser results.
// Depends on nothing.
`timescale 1ns / 1ps

interface wshp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface wshp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [2:0] error_class;
   logic [2:0] handshake_flags;
   modport source (output valid, output status, output error_class, output handshake_flags,
                   input ready);
   modport sink   (input valid, input status, input error_class, input handshake_flags,
                   output ready);
endinterface

[rtl/websocket_handshake_header_parser.sv]
// WebSocket upgrade request parser, top level: sequencer and token checks.
// Depends on wshp_pkg, wshp_chan_if, wshp_tokenizer, wshp_token_mem.
`timescale 1ns / 1ps

// Takes one request byte per item and answers each with one result (status,
// error class, handshake flags). A byte that extends a token, is skipped, or
// arrives after the outcome is settled needs no walk. A byte that ends a token
// starts a walk over the token buffer through its single read port and takes
// no new byte meanwhile: for header names and values, trailing blanks are
// stripped first, then each remaining token byte is read and compared, then
// the checks are made. A byte that ends a header value and starts the next
// name is classified again, with a second walk if it also ends a token. The
// result register accepts the next byte in the same cycle its item is taken.
module websocket_handshake_header_parser #(
   parameter int TOKEN_BUFFER_DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   wshp_req_if.sink          req_chan,
   wshp_rsp_if.source        rsp_chan
);

   localparam int AW = $clog2(TOKEN_BUFFER_DEPTH);
   localparam logic [AW-1:0] MAX_LEN = AW'(TOKEN_BUFFER_DEPTH - 1);
   localparam int NUM_W = wshp_pkg::NUM_WORDS;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_STRIP_RD  = 3'd1;
   localparam logic [2:0] S_STRIP_CHK = 3'd2;
   localparam logic [2:0] S_CMP_RD    = 3'd3;
   localparam logic [2:0] S_CMP_CHK   = 3'd4;
   localparam logic [2:0] S_EVAL      = 3'd5;
   localparam logic [2:0] S_PASS2     = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [2:0]    pe_ff, pe_in;
   logic [2:0]    te_ff, te_in;
   logic [2:0]    phase_ff, phase_in;
   logic [2:0]    class_ff, class_in;
   logic [2:0]    bits_ff, bits_in;
   logic          key_ff, key_in;
   logic          slash_ff, slash_in;
   logic [1:0]    final_ff, final_in;
   logic [2:0]    ferr_ff, ferr_in;
   logic [AW-1:0] len_ff, len_in;
   logic [AW-1:0] n_ff, n_in;
   logic [AW-1:0] i_ff, i_in;
   logic [2:0]    kind_ff, kind_in;
   logic [7:0]    byte_ff, byte_in;
   logic          pass2_ff, pass2_in;
   logic          out_valid_ff, out_valid_in;
   logic [NUM_W-1:0] match_ff, match_in;
   logic          first_slash_ff, first_slash_in;
   logic          lst_start_ff, lst_start_in;
   logic [3:0]    lst_pos_ff, lst_pos_in;
   logic          lst_ok_ff, lst_ok_in;
   logic          lst_found_ff, lst_found_in;

   logic                     accept;
   logic [7:0]               tok_byte;
   wshp_pkg::tok_result_type tk;
   logic                     wr_en;
   logic [AW-1:0]            rd_addr;
   logic [7:0]               rd_data;
   logic [7:0]               rd_low;

   // token-end evaluation
   logic [2:0] ev_err;
   logic [2:0] ev_phase, ev_te, ev_class, ev_bits;
   logic       ev_key, ev_slash, ev_list;
   logic [2:0] ev_final_err;

   assign accept   = req_chan.valid && req_chan.ready;
   assign tok_byte = (state_ff == S_PASS2) ? byte_ff : req_chan.data_byte;
   assign rd_low   = wshp_pkg::lower_ascii(rd_data);

   assign req_chan.ready       = (state_ff == S_IDLE) && (!out_valid_ff || rsp_chan.ready);
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = final_ff;
   assign rsp_chan.error_class = ferr_ff;
   assign rsp_chan.handshake_flags = bits_ff;

   wshp_tokenizer u_tok (
      .c   (tok_byte),
      .pe  (pe_ff),
      .te  (te_ff),
      .res (tk)
   );

   // buffer writes happen only in IDLE/PASS2; read data is used only during a walk
   assign rd_addr = (state_ff == S_STRIP_RD) ? n_ff - AW'(1) : i_ff;

   wshp_token_mem #(
      .DEPTH (TOKEN_BUFFER_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff),
      .wr_data (tk.ch),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      ev_err   = wshp_pkg::ERR_NONE;
      ev_phase = phase_ff;
      ev_te    = te_ff;
      ev_class = class_ff;
      ev_bits  = bits_ff;
      ev_key   = key_ff;
      ev_slash = slash_ff;
      ev_list  = lst_found_ff || (lst_ok_ff && lst_pos_ff == 4'd7);
      case (phase_ff)
         wshp_pkg::PH_METHOD: begin
            if (!(match_ff[wshp_pkg::W_GET] && n_ff == AW'(3)))
               ev_err = wshp_pkg::ERR_METHOD;
            ev_phase = wshp_pkg::PH_PATH;
         end
         wshp_pkg::PH_PATH: begin
            ev_slash = first_slash_ff;
            ev_phase = wshp_pkg::PH_VERSION;
            ev_te    = wshp_pkg::TE_EOL_NOCONT;
         end
         wshp_pkg::PH_VERSION: begin
            if (!(match_ff[wshp_pkg::W_HTTP11] && n_ff == AW'(8)))
               ev_err = wshp_pkg::ERR_VERSION;
            ev_phase = wshp_pkg::PH_FIELD;
            ev_te    = wshp_pkg::TE_COLON;
         end
         wshp_pkg::PH_FIELD: begin
            if (match_ff[wshp_pkg::W_UPGRADE] && n_ff == AW'(7))
               ev_class = wshp_pkg::HN_UPGRADE;
            else if (match_ff[wshp_pkg::W_CONNECT] && n_ff == AW'(10))
               ev_class = wshp_pkg::HN_CONNECTION;
            else if (match_ff[wshp_pkg::W_SECVER] && n_ff == AW'(21))
               ev_class = wshp_pkg::HN_VERSION;
            else if (match_ff[wshp_pkg::W_SECKEY] && n_ff == AW'(17))
               ev_class = wshp_pkg::HN_KEY;
            else
               ev_class = wshp_pkg::HN_OTHER;
            ev_phase = wshp_pkg::PH_VALUE;
            ev_te    = wshp_pkg::TE_EOL;
         end
         wshp_pkg::PH_VALUE: begin
            case (class_ff)
               wshp_pkg::HN_UPGRADE: begin
                  if (match_ff[wshp_pkg::W_WEBSOCKET] && n_ff == AW'(9))
                     ev_bits = bits_ff | 3'b001;
                  else
                     ev_err = wshp_pkg::ERR_BAD_VALUE;
               end
               wshp_pkg::HN_CONNECTION: begin
                  if (ev_list) ev_bits = bits_ff | 3'b010;
                  else         ev_err  = wshp_pkg::ERR_BAD_VALUE;
               end
               wshp_pkg::HN_VERSION: begin
                  if (match_ff[wshp_pkg::W_13] && n_ff == AW'(2))
                     ev_bits = bits_ff | 3'b100;
                  else
                     ev_err = wshp_pkg::ERR_BAD_VALUE;
               end
               wshp_pkg::HN_KEY: begin
                  if (key_ff) ev_err = wshp_pkg::ERR_REPEATED;
                  else        ev_key = 1'b1;
               end
               default: ;
            endcase
            ev_phase = wshp_pkg::PH_FIELD;
            ev_te    = wshp_pkg::TE_COLON;
         end
         default: ev_err = wshp_pkg::ERR_MALFORMED;
      endcase

      // end-of-headers verdict, using the values this token just produced
      if (ev_bits != 3'b111)  ev_final_err = wshp_pkg::ERR_MALFORMED;
      else if (!ev_slash)     ev_final_err = wshp_pkg::ERR_PATH;
      else if (!ev_key)       ev_final_err = wshp_pkg::ERR_MALFORMED;
      else                    ev_final_err = wshp_pkg::ERR_NONE;
   end

   always_comb begin
      state_in       = state_ff;
      pe_in          = pe_ff;
      te_in          = te_ff;
      phase_in       = phase_ff;
      class_in       = class_ff;
      bits_in        = bits_ff;
      key_in         = key_ff;
      slash_in       = slash_ff;
      final_in       = final_ff;
      ferr_in        = ferr_ff;
      len_in         = len_ff;
      n_in           = n_ff;
      i_in           = i_ff;
      kind_in        = kind_ff;
      byte_in        = byte_ff;
      pass2_in       = pass2_ff;
      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      match_in       = match_ff;
      first_slash_in = first_slash_ff;
      lst_start_in   = lst_start_ff;
      lst_pos_in     = lst_pos_ff;
      lst_ok_in      = lst_ok_ff;
      lst_found_in   = lst_found_ff;
      wr_en          = 1'b0;

      case (state_ff)
         S_IDLE, S_PASS2: begin
            if (state_ff == S_PASS2 || (accept && final_ff == wshp_pkg::ST_MORE)) begin
               pe_in    = tk.pe_next;
               state_in = S_IDLE;
               case (tk.kind)
                  wshp_pkg::TK_SKIP: out_valid_in = 1'b1;
                  wshp_pkg::TK_ABORT: begin
                     final_in     = wshp_pkg::ST_REJECT;
                     ferr_in      = wshp_pkg::ERR_MALFORMED;
                     out_valid_in = 1'b1;
                  end
                  wshp_pkg::TK_CHAR: begin
                     if (len_ff >= MAX_LEN) begin
                        final_in = wshp_pkg::ST_REJECT;
                        ferr_in  = wshp_pkg::ERR_TOO_LONG;
                     end else begin
                        wr_en  = 1'b1;
                        len_in = len_ff + AW'(1);
                     end
                     out_valid_in = 1'b1;
                  end
                  default: begin
                     kind_in        = tk.kind;
                     byte_in        = tok_byte;
                     pass2_in       = (state_ff == S_PASS2);
                     n_in           = len_ff;
                     i_in           = '0;
                     match_in       = '1;
                     first_slash_in = 1'b0;
                     lst_start_in   = 1'b1;
                     lst_pos_in     = 4'd0;
                     lst_ok_in      = 1'b1;
                     lst_found_in   = 1'b0;
                     state_in = (phase_ff == wshp_pkg::PH_FIELD ||
                                 phase_ff == wshp_pkg::PH_VALUE) ? S_STRIP_RD : S_CMP_RD;
                  end
               endcase
            end else if (accept) begin
               out_valid_in = 1'b1;
            end
         end
         S_STRIP_RD: begin
            state_in = (n_ff == '0) ? S_CMP_RD : S_STRIP_CHK;
         end
         S_STRIP_CHK: begin
            if (rd_data == wshp_pkg::CH_SP || rd_data == wshp_pkg::CH_TAB ||
                rd_data == wshp_pkg::CH_VT || rd_data == wshp_pkg::CH_FF) begin
               n_in     = n_ff - AW'(1);
               state_in = S_STRIP_RD;
            end else begin
               state_in = S_CMP_RD;
            end
         end
         S_CMP_RD: begin
            state_in = (i_ff == n_ff) ? S_EVAL : S_CMP_CHK;
         end
         S_CMP_CHK: begin
            for (int w = 0; w < NUM_W; w++) begin
               if (i_ff < AW'(wshp_pkg::word_len(3'(w)))) begin
                  if (wshp_pkg::word_folds(3'(w))) begin
                     if (rd_low != wshp_pkg::word_byte(3'(w), i_ff[4:0])) match_in[w] = 1'b0;
                  end else begin
                     if (rd_data != wshp_pkg::word_byte(3'(w), i_ff[4:0])) match_in[w] = 1'b0;
                  end
               end
            end
            if (i_ff == '0 && rd_data == wshp_pkg::CH_SLASH) first_slash_in = 1'b1;
            // comma list scan for the Connection value
            if (lst_start_ff && wshp_pkg::is_blank(rd_data)) begin
               lst_start_in = 1'b1;
            end else if (rd_data == wshp_pkg::CH_COMMA) begin
               if (lst_ok_ff && lst_pos_ff == 4'd7) lst_found_in = 1'b1;
               lst_start_in = 1'b1;
               lst_pos_in   = 4'd0;
               lst_ok_in    = 1'b1;
            end else begin
               lst_start_in = 1'b0;
               if (lst_pos_ff < 4'd7 &&
                   rd_low == wshp_pkg::word_byte(wshp_pkg::W_UPGRADE, 5'(lst_pos_ff)))
                  lst_pos_in = lst_pos_ff + 4'd1;
               else
                  lst_ok_in = 1'b0;
            end
            i_in     = i_ff + AW'(1);
            state_in = S_CMP_RD;
         end
         S_EVAL: begin
            state_in = S_IDLE;
            if (ev_err != wshp_pkg::ERR_NONE) begin
               final_in     = wshp_pkg::ST_REJECT;
               ferr_in      = ev_err;
               out_valid_in = 1'b1;
            end else begin
               phase_in = ev_phase;
               te_in    = ev_te;
               class_in = ev_class;
               bits_in  = ev_bits;
               key_in   = ev_key;
               slash_in = ev_slash;
               len_in   = '0;
               if (kind_ff == wshp_pkg::TK_END_HEADERS) begin
                  final_in = (ev_final_err == wshp_pkg::ERR_NONE) ? wshp_pkg::ST_ACCEPT
                                                                  : wshp_pkg::ST_REJECT;
                  ferr_in      = ev_final_err;
                  out_valid_in = 1'b1;
               end else if (kind_ff == wshp_pkg::TK_END_AGAIN && !pass2_ff) begin
                  state_in = S_PASS2;
               end else begin
                  out_valid_in = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pe_ff        <= wshp_pkg::PE_NONE;
         te_ff        <= wshp_pkg::TE_SPACE;
         phase_ff     <= wshp_pkg::PH_METHOD;
         class_ff     <= wshp_pkg::HN_OTHER;
         bits_ff      <= '0;
         key_ff       <= 1'b0;
         slash_ff     <= 1'b0;
         final_ff     <= wshp_pkg::ST_MORE;
         ferr_ff      <= wshp_pkg::ERR_NONE;
         len_ff       <= '0;
         pass2_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pe_ff        <= pe_in;
         te_ff        <= te_in;
         phase_ff     <= phase_in;
         class_ff     <= class_in;
         bits_ff      <= bits_in;
         key_ff       <= key_in;
         slash_ff     <= slash_in;
         final_ff     <= final_in;
         ferr_ff      <= ferr_in;
         len_ff       <= len_in;
         pass2_ff     <= pass2_in;
         out_valid_ff <= out_valid_in;
      end
      n_ff           <= n_in;
      i_ff           <= i_in;
      kind_ff        <= kind_in;
      byte_ff        <= byte_in;
      match_ff       <= match_in;
      first_slash_ff <= first_slash_in;
      lst_start_ff   <= lst_start_in;
      lst_pos_ff     <= lst_pos_in;
      lst_ok_ff      <= lst_ok_in;
      lst_found_ff   <= lst_found_in;
   end

   a_outcome_held: assert property (@(posedge clock) disable iff (reset)
      (final_ff != wshp_pkg::ST_MORE) |=> (final_ff == $past(final_ff)))
      else $error("settled outcome changed");

   a_err_matches_status: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((final_ff == wshp_pkg::ST_REJECT) == (ferr_ff != wshp_pkg::ERR_NONE)))
      else $error("error class disagrees with status");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= MAX_LEN)
      else $error("token length beyond buffer");

   a_flags_sticky: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (($past(bits_ff) & ~bits_ff) == 3'b000))
      else $error("handshake flag cleared");

endmodule

[rtl/wshp_tokenizer.sv]
// Byte classifier: decides whether a byte extends, ends or aborts the token, or is skipped.
// Depends on wshp_pkg.
`timescale 1ns / 1ps

module wshp_tokenizer (
   input  logic [7:0]              c,
   input  logic [2:0]              pe,
   input  logic [2:0]              te,
   output wshp_pkg::tok_result_type res
);

   logic done;

   always_comb begin
      res.kind    = wshp_pkg::TK_CHAR;
      res.ch      = c;
      res.pe_next = wshp_pkg::PE_NONE;
      done        = 1'b0;

      case (pe)
         wshp_pkg::PE_SKIP_BLANKS: begin
            if (wshp_pkg::is_blank(c)) begin
               res.kind    = wshp_pkg::TK_SKIP;
               res.pe_next = wshp_pkg::PE_SKIP_BLANKS;
               done        = 1'b1;
            end
         end
         wshp_pkg::PE_LF, wshp_pkg::PE_LF_NOCONT: begin
            res.pe_next = (pe == wshp_pkg::PE_LF) ? wshp_pkg::PE_LINE_CONT
                                                  : wshp_pkg::PE_LINE_NOCONT;
            res.kind    = (c == wshp_pkg::CH_LF) ? wshp_pkg::TK_SKIP : wshp_pkg::TK_ABORT;
            done        = 1'b1;
         end
         wshp_pkg::PE_LF_END: begin
            res.kind = (c == wshp_pkg::CH_LF) ? wshp_pkg::TK_END_HEADERS : wshp_pkg::TK_ABORT;
            done     = 1'b1;
         end
         wshp_pkg::PE_LINE_CONT, wshp_pkg::PE_LINE_NOCONT: begin
            done = 1'b1;
            if (wshp_pkg::is_blank(c)) begin
               if (pe == wshp_pkg::PE_LINE_NOCONT) begin
                  res.kind    = wshp_pkg::TK_ABORT;
                  res.pe_next = pe;
               end else begin
                  // folded continuation: blanks collapse to one space
                  res.pe_next = wshp_pkg::PE_SKIP_BLANKS;
                  res.ch      = wshp_pkg::CH_SP;
               end
            end else if (c == wshp_pkg::CH_LF) begin
               res.kind = wshp_pkg::TK_END_HEADERS;
            end else if (c == wshp_pkg::CH_CR) begin
               res.kind    = wshp_pkg::TK_SKIP;
               res.pe_next = wshp_pkg::PE_LF_END;
            end else begin
               res.kind = wshp_pkg::TK_END_AGAIN;
            end
         end
         default: ;
      endcase

      if (!done) begin
         case (te)
            wshp_pkg::TE_SPACE: begin
               if (c == wshp_pkg::CH_SP) begin
                  res.kind = wshp_pkg::TK_END;
                  done     = 1'b1;
               end
            end
            wshp_pkg::TE_BLANKS: begin
               if (wshp_pkg::is_blank(c)) begin
                  res.kind    = wshp_pkg::TK_END;
                  res.pe_next = wshp_pkg::PE_SKIP_BLANKS;
                  done        = 1'b1;
               end
            end
            wshp_pkg::TE_COLON: begin
               if (c == wshp_pkg::CH_COLON) begin
                  res.kind    = wshp_pkg::TK_END;
                  res.pe_next = wshp_pkg::PE_SKIP_BLANKS;
                  done        = 1'b1;
               end
            end
            wshp_pkg::TE_EOL, wshp_pkg::TE_EOL_NOCONT: begin
               if (c == wshp_pkg::CH_CR) begin
                  res.kind    = wshp_pkg::TK_SKIP;
                  res.pe_next = (te == wshp_pkg::TE_EOL) ? wshp_pkg::PE_LF
                                                         : wshp_pkg::PE_LF_NOCONT;
                  done        = 1'b1;
               end else if (c == wshp_pkg::CH_LF) begin
                  res.kind    = wshp_pkg::TK_SKIP;
                  res.pe_next = (te == wshp_pkg::TE_EOL) ? wshp_pkg::PE_LINE_CONT
                                                         : wshp_pkg::PE_LINE_NOCONT;
                  done        = 1'b1;
               end
            end
            default: ;
         endcase
         if (!done && (c == wshp_pkg::CH_LF || c == wshp_pkg::CH_CR || c == wshp_pkg::CH_NUL))
            res.kind = wshp_pkg::TK_ABORT;
      end
   end

endmodule

[rtl/wshp_token_mem.sv]
// Token buffer: single-port write, registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module wshp_token_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[test/tb.sv]
// Self-checking bench for websocket_handshake_header_parser: one long request stream,
// byte-by-byte prediction of status, error class and handshake flags.
// Depends on wshp_pkg, wshp_chan_if and the parser RTL.
`timescale 1ns / 1ps

module tb;
   import wshp_pkg::*;

   localparam int DEPTH = 1024;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic [1:0] status;
      logic [2:0] error_class;
      logic [2:0] flags;
   } verdict_t;

   typedef struct {
      logic [7:0] data;
      bit         known;
      verdict_t   v;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #1 clock = ~clock;

   wshp_req_if req_chan();
   wshp_rsp_if rsp_chan();

   websocket_handshake_header_parser #(.TOKEN_BUFFER_DEPTH(DEPTH)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // parser state mirror
   logic [2:0] p_pend, p_tend, p_phase, p_hname, p_bits;
   logic [7:0] p_buf [DEPTH];
   int         p_len;
   bit         p_key, p_slash;
   logic [1:0] p_out;
   logic [2:0] p_err;

   verdict_t verdict_q[$];
   row_t     row_q[$];   // driven rows, in order, for the monitor
   row_t     stim[$];
   int       fail_count = 0;
   int       cycles = 0;
   int       tx_idle_pct = 0, rx_stall_pct = 0;
   bit       key_used = 0;

   function automatic bit blank(input logic [7:0] c);
      return c == CH_SP || c == CH_TAB;
   endfunction

   function automatic logic [7:0] fold_lower(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic bit span_eq(input int from, input int to, input string w, input bit fold);
      logic [7:0] a, b;
      for (int i = 0; i < w.len(); i++) begin
         if (from + i >= to || from + i >= DEPTH) return 0;
         a = p_buf[from + i];
         b = w[i];
         if (fold) begin
            a = fold_lower(a);
            b = fold_lower(b);
         end
         if (a != b) return 0;
      end
      return from + w.len() == to;
   endfunction

   function automatic int stripped_len();
      int         n;
      logic [7:0] c;
      n = p_len;
      while (n > 0) begin
         c = p_buf[(n - 1) % DEPTH];
         if (c != CH_SP && c != CH_TAB && c != CH_VT && c != CH_FF) break;
         n--;
      end
      return n;
   endfunction

   function automatic bit lists_upgrade(input int len);
      int i, j;
      i = 0;
      forever begin
         while (i < len && blank(p_buf[i])) i++;
         j = i;
         while (j < len && p_buf[j] != CH_COMMA) j++;
         if (span_eq(i, j, "upgrade", 1)) return 1;
         if (j >= len) return 0;
         i = j + 1;
      end
   endfunction

   function automatic logic [2:0] classify(input logic [7:0] c, output logic [7:0] ch);
      ch = c;
      case (p_pend)
         PE_SKIP_BLANKS: begin
            if (blank(c)) return TK_SKIP;
            p_pend = PE_NONE;
         end
         PE_LF: begin
            p_pend = PE_LINE_CONT;
            return c == CH_LF ? TK_SKIP : TK_ABORT;
         end
         PE_LF_NOCONT: begin
            p_pend = PE_LINE_NOCONT;
            return c == CH_LF ? TK_SKIP : TK_ABORT;
         end
         PE_LF_END: begin
            p_pend = PE_NONE;
            return c == CH_LF ? TK_END_HEADERS : TK_ABORT;
         end
         PE_LINE_CONT, PE_LINE_NOCONT: begin
            if (blank(c)) begin
               if (p_pend == PE_LINE_NOCONT) return TK_ABORT;
               p_pend = PE_SKIP_BLANKS;
               ch = CH_SP;
               return TK_CHAR;
            end
            p_pend = PE_NONE;
            if (c == CH_LF) return TK_END_HEADERS;
            if (c == CH_CR) begin
               p_pend = PE_LF_END;
               return TK_SKIP;
            end
            return TK_END_AGAIN;
         end
         default: p_pend = PE_NONE;
      endcase
      case (p_tend)
         TE_SPACE: if (c == CH_SP) return TK_END;
         TE_BLANKS: if (blank(c)) begin
            p_pend = PE_SKIP_BLANKS;
            return TK_END;
         end
         TE_COLON: if (c == CH_COLON) begin
            p_pend = PE_SKIP_BLANKS;
            return TK_END;
         end
         TE_EOL, TE_EOL_NOCONT: begin
            if (c == CH_CR) begin
               p_pend = (p_tend == TE_EOL) ? PE_LF : PE_LF_NOCONT;
               return TK_SKIP;
            end
            if (c == CH_LF) begin
               p_pend = (p_tend == TE_EOL) ? PE_LINE_CONT : PE_LINE_NOCONT;
               return TK_SKIP;
            end
         end
         default: ;
      endcase
      if (c == CH_LF || c == CH_CR || c == CH_NUL) return TK_ABORT;
      return TK_CHAR;
   endfunction

   function automatic logic [2:0] close_token();
      int n;
      case (p_phase)
         PH_METHOD: begin
            if (!span_eq(0, p_len, "GET", 0)) return ERR_METHOD;
            p_phase = PH_PATH;
         end
         PH_PATH: begin
            p_slash = p_len > 0 && p_buf[0] == CH_SLASH;
            p_phase = PH_VERSION;
            p_tend = TE_EOL_NOCONT;
         end
         PH_VERSION: begin
            if (!span_eq(0, p_len, "HTTP/1.1", 0)) return ERR_VERSION;
            p_phase = PH_FIELD;
            p_tend = TE_COLON;
         end
         PH_FIELD: begin
            n = stripped_len();
            if (span_eq(0, n, "upgrade", 1)) p_hname = HN_UPGRADE;
            else if (span_eq(0, n, "connection", 1)) p_hname = HN_CONNECTION;
            else if (span_eq(0, n, "sec-websocket-version", 1)) p_hname = HN_VERSION;
            else if (span_eq(0, n, "sec-websocket-key", 1)) p_hname = HN_KEY;
            else p_hname = HN_OTHER;
            p_phase = PH_VALUE;
            p_tend = TE_EOL;
         end
         PH_VALUE: begin
            n = stripped_len();
            if (p_hname == HN_UPGRADE) begin
               if (!span_eq(0, n, "websocket", 1)) return ERR_BAD_VALUE;
               p_bits[0] = 1'b1;
            end else if (p_hname == HN_CONNECTION) begin
               if (!lists_upgrade(n)) return ERR_BAD_VALUE;
               p_bits[1] = 1'b1;
            end else if (p_hname == HN_VERSION) begin
               if (!span_eq(0, n, "13", 0)) return ERR_BAD_VALUE;
               p_bits[2] = 1'b1;
            end else if (p_hname == HN_KEY) begin
               if (p_key) return ERR_REPEATED;
               p_key = 1;
            end
            p_phase = PH_FIELD;
            p_tend = TE_COLON;
         end
         default: return ERR_MALFORMED;
      endcase
      return ERR_NONE;
   endfunction

   function automatic void settle(input logic [2:0] e);
      p_out = (e == ERR_NONE) ? ST_ACCEPT : ST_REJECT;
      p_err = e;
   endfunction

   function automatic verdict_t parse_byte(input logic [7:0] c);
      logic [2:0] kind, e;
      logic [7:0] ch;
      verdict_t   v;
      for (int pass = 0; pass < 2 && p_out == ST_MORE; pass++) begin
         kind = classify(c, ch);
         if (kind == TK_SKIP) break;
         if (kind == TK_ABORT) begin
            settle(ERR_MALFORMED);
            break;
         end
         if (kind == TK_CHAR) begin
            if (p_len >= DEPTH - 1) settle(ERR_TOO_LONG);
            else begin
               p_buf[p_len] = ch;
               p_len++;
            end
            break;
         end
         e = close_token();
         if (e != ERR_NONE) begin
            settle(e);
            break;
         end
         p_len = 0;
         if (kind == TK_END_HEADERS) begin
            if (p_bits != 3'b111) settle(ERR_MALFORMED);
            else if (!p_slash) settle(ERR_PATH);
            else if (!p_key) settle(ERR_MALFORMED);
            else settle(ERR_NONE);
            break;
         end
         if (kind == TK_END) break;
      end
      v.status = p_out;
      v.error_class = p_err;
      v.flags = p_bits;
      return v;
   endfunction

   // ---------------- stimulus building ----------------
   function automatic void add_byte(input logic [7:0] b);
      row_t r;
      r.data = b;
      r.known = 0;
      r.v = '{default: '0};
      stim.push_back(r);
   endfunction

   function automatic void add_str(input string s, input bit scramble);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (scramble && c >= "a" && c <= "z" && $urandom_range(1)) c = c - 8'd32;
         add_byte(c);
      end
   endfunction

   function automatic void add_eol();
      if ($urandom_range(1)) add_byte(CH_CR);
      add_byte(CH_LF);
   endfunction

   function automatic logic [7:0] name_char();
      case ($urandom_range(3))
         0: return 8'($urandom_range("z", "a"));
         1: return $urandom_range(1) ? "-" : 8'($urandom_range("9", "0"));
         2: return 8'($urandom_range(8'hFF, 8'h80));
         default: begin
            logic [7:0] c;
            do c = 8'($urandom_range(8'h7E, 8'h21)); while (c == CH_COLON);
            return c;
         end
      endcase
   endfunction

   function automatic logic [7:0] value_char();
      logic [7:0] c;
      do c = 8'($urandom_range(8'hFF, 8'h01)); while (c == CH_LF || c == CH_CR);
      return c;
   endfunction

   function automatic void add_pad(input int most);
      logic [7:0] pads [4] = '{CH_SP, CH_TAB, CH_VT, CH_FF};
      repeat ($urandom_range(most)) add_byte(pads[$urandom_range(3)]);
   endfunction

   function automatic void add_colon();
      add_byte(CH_COLON);
      repeat ($urandom_range(2)) add_byte($urandom_range(1) ? CH_SP : CH_TAB);
   endfunction

   function automatic void add_other_header(input int vlen);
      repeat ($urandom_range(12, 1)) add_byte(name_char());
      add_pad(1);
      add_colon();
      repeat (vlen) add_byte(value_char());
      add_pad(2);
      add_eol();
      // folded continuation lines
      while ($urandom_range(3) == 0) begin
         repeat ($urandom_range(3, 1)) add_byte($urandom_range(1) ? CH_SP : CH_TAB);
         repeat ($urandom_range(10)) add_byte(value_char());
         add_eol();
      end
   endfunction

   function automatic void add_known_header(input string name, input string val,
                                            input bit scramble_val);
      add_str(name, 1);
      add_pad(1);
      add_colon();
      add_str(val, scramble_val);
      add_pad(2);
      add_eol();
   endfunction

   function automatic void add_key();
      add_known_header("sec-websocket-key", "dGhlIHNhbXBsZSBub25jZQ==", 0);
   endfunction

   function automatic void build_random(input int target);
      string conn [3] = '{"upgrade", "keep-alive, upgrade", "foo,\tupgrade"};
      bit    long_done = 0;
      while (stim.size() < target) begin
         case ($urandom_range(9))
            0: add_known_header("upgrade", "websocket", 1);
            1: add_known_header("connection", conn[$urandom_range(2)], 1);
            2: add_known_header("sec-websocket-version", "13", 0);
            3: if (!key_used && $urandom_range(3) == 0) begin
               add_key();
               key_used = 1;
            end
            default: begin
               if (!long_done && stim.size() > target / 2) begin
                  add_other_header(1000);
                  long_done = 1;
               end else add_other_header($urandom_range(30));
            end
         endcase
      end
      // closing: half the time a clean end, else a broken one
      case ($urandom_range(7))
         4: add_byte(CH_NUL);
         5: begin
            if (!key_used) add_key();
            add_key();
         end
         6: add_known_header("upgrade", "h2c", 0);
         7: begin
            add_str("x-big", 0);
            add_colon();
            repeat (DEPTH + 8) add_byte(value_char());
         end
         default: begin
            add_known_header("upgrade", "websocket", 1);
            add_known_header("connection", "upgrade", 1);
            add_known_header("sec-websocket-version", "13", 0);
            if (!key_used) add_key();
            add_eol();
         end
      endcase
      // held outcome: later bytes change nothing
      repeat (20) add_byte(8'($urandom_range(255)));
   endfunction

   // ---------------- checking ----------------
   always @(posedge clock) begin
      row_t     r;
      verdict_t v, got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            v = parse_byte(req_chan.data_byte);
            r = row_q.pop_front();
            verdict_q.push_back(r.known ? r.v : v);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.status = rsp_chan.status;
            got.error_class = rsp_chan.error_class;
            got.flags = rsp_chan.handshake_flags;
            if (verdict_q.size() == 0) begin
               $error("result with nothing expected");
               fail_count++;
            end else begin
               v = verdict_q.pop_front();
               if (got.status !== v.status) begin
                  $error("status: expected %0d, got %0d", v.status, got.status);
                  fail_count++;
               end
               if (got.error_class !== v.error_class) begin
                  $error("error_class: expected %0d, got %0d", v.error_class, got.error_class);
                  fail_count++;
               end
               if (got.flags !== v.flags) begin
                  $error("handshake_flags: expected %0d, got %0d", v.flags, got.flags);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_chan.ready <= reset ? 1'b0 : ($urandom_range(99) >= rx_stall_pct);
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** websocket_handshake_header_parser: FAILED **");
         $finish;
      end
   end

   task automatic send_row(input row_t r);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      row_q.push_back(r);
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= r.data;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   initial begin
      row_t  r;
      string head;
      int    n_dir, total;
      req_chan.valid <= 1'b0;
      req_chan.data_byte <= 8'h00;
      p_pend = PE_NONE;
      p_tend = TE_SPACE;
      p_phase = PH_METHOD;
      p_len = 0;
      p_hname = HN_OTHER;
      p_bits = 3'b000;
      p_key = 0;
      p_slash = 0;
      p_out = ST_MORE;
      p_err = ERR_NONE;

      // directed request line: top-bit bytes in the path; every byte answers "more"
      head = "GET /";
      foreach (head[i]) add_byte(head[i]);
      add_byte(8'hFF);
      add_byte(8'h80);
      head = " HTTP/1.1";
      foreach (head[i]) add_byte(head[i]);
      add_byte(CH_CR);
      add_byte(CH_LF);
      foreach (stim[i]) begin
         stim[i].known = 1;
         stim[i].v = '{ST_MORE, ERR_NONE, 3'b000};
      end
      n_dir = stim.size();
      build_random(1450);
      total = stim.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < total; i++) begin
         if (i == n_dir) begin
            // let everything drain once before the random part
            req_chan.valid <= 1'b0;
            wait (verdict_q.size() == 0 && row_q.size() == 0);
            @(posedge clock);
         end
         case ((i * 4) / total)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 69; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 69; end
            default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
         endcase
         send_row(stim[i]);
      end
      req_chan.valid <= 1'b0;
      wait (verdict_q.size() == 0 && row_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("** websocket_handshake_header_parser: PASSED **");
      else
         $display("** websocket_handshake_header_parser: FAILED **");
      $finish;
   end

endmodule

[files.f]
rtl/wshp_pkg.sv
rtl/wshp_chan_if.sv
rtl/wshp_tokenizer.sv
rtl/wshp_token_mem.sv
rtl/websocket_handshake_header_parser.sv
test/tb.sv
